/* hw/rtl/ppk_pkg.sv */
// Shared types, constants and arithmetic helpers for the particle pool core.
`default_nettype none
package ppk_pkg;

    localparam int PPK_POOL_SLOTS = 64;

    localparam logic [7:0] CFG_AIR_RESISTANCE = 8'd0;
    localparam logic [7:0] CFG_GRAVITY_ACCEL  = 8'd1;
    localparam logic [7:0] CFG_LIFE_MAX       = 8'd2;

    localparam logic [16:0] AIR_RESET  = 17'd65536;
    localparam logic [31:0] LIFE_RESET = 32'd65536;

    typedef struct packed {
        logic        opcode;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] accel_x;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] time_step;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  slot_index;
        logic        visible;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [7:0]  alpha;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] accel_x;
        logic [31:0] accel_y;
        logic [31:0] life;
        logic [23:0] color;
    } t_slot;

    typedef struct packed {
        logic spawn;
        logic tick;
        logic prep;
        logic rd;
        logic mul;
        logic upd;
        logic wr;
        logic step;
        logic fin;
        logic next;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic idx_last;
    } t_sts;

    function automatic logic signed [65:0] ppk_rnd(input logic signed [65:0] x,
                                                   input logic [5:0] s);
        logic signed [65:0] h;
        h = 66'sd1 <<< (s - 6'd1);
        return (x + h) >>> s;
    endfunction

    function automatic logic [31:0] ppk_sat(input logic signed [35:0] v);
        if (v > $signed(36'h07FFFFFFF)) begin
            return 32'h7FFFFFFF;
        end else if (v < $signed(36'hF80000000)) begin
            return 32'h80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ppk_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/ppk_ctrl.sv */
// Controller state machine sequencing spawn and tick transactions.
`default_nettype none
module ppk_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_opcode,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire ppk_pkg::t_sts i_sts,
    output ppk_pkg::t_cmd      o_cmd
);
    import ppk_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_RD   = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_UPD  = 9'b000010000,
        S_WR   = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode) begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_PREP;
                    end else begin
                        o_cmd.spawn = 1'b1;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.next = 1'b1;
                    n_state    = i_sts.idx_last ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_out_ready) |=> r_state == S_OUT)
        else $error("result dropped before transaction");
    a_div_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_done) |=> r_state == S_DIV)
        else $error("divider left early");
    a_tick_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_out_ready && i_sts.idx_last) |=> r_state == S_IDLE)
        else $error("tick did not end after last slot");
endmodule
`default_nettype wire

/* hw/rtl/ppk_dpath.sv */
// Datapath: slot memory, kinematic update, alpha divider, config and result registers.
`default_nettype none
module ppk_dpath #(
    parameter int POOL_SLOTS = ppk_pkg::PPK_POOL_SLOTS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ppk_pkg::t_cmd       i_cmd,
    output ppk_pkg::t_sts            o_sts,
    input  wire ppk_pkg::t_in_item   i_in_data,
    input  wire logic                i_cfg_valid,
    input  wire logic [7:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data,
    output ppk_pkg::t_out_item       o_out_data
);
    import ppk_pkg::*;

    localparam int IW = $clog2(POOL_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SLOTS - 1);

    logic [16:0]         r_air;
    logic [31:0]         r_grav;
    logic [31:0]         r_lmax;
    logic [IW-1:0]       r_wslot;
    logic [IW-1:0]       r_idx;
    logic [POOL_SLOTS-1:0] r_valid;
    logic                r_rd_valid;
    logic [15:0]         r_dt;
    logic [31:0]         r_dtsq;
    t_slot               r_rec, r_new, n_new, rec_q, spawn_rec;
    logic [$bits(t_slot)-1:0] ram_q, ram_wdata;
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;

    logic signed [48:0]  r_p_vxdt, r_p_vydt, r_p_axdt, r_p_aydt;
    logic signed [64:0]  r_p_axdt2, r_p_aydt2;
    logic signed [49:0]  r_p_vxk;

    logic [40:0]         r_rem, n_num, dsr;
    logic [8:0]          r_q;
    logic [3:0]          r_cnt;

    logic signed [35:0]  s_x, s_y, s_vx, s_vy;
    logic signed [16:0]  dt_s;
    logic signed [32:0]  dtsq_s;
    logic signed [17:0]  k_s;
    logic                live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air  <= AIR_RESET;
            r_grav <= '0;
            r_lmax <= LIFE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AIR_RESISTANCE: r_air  <= i_cfg_data[16:0];
                CFG_GRAVITY_ACCEL:  r_grav <= i_cfg_data;
                CFG_LIFE_MAX:       r_lmax <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        spawn_rec.pos_x   = i_in_data.pos_x;
        spawn_rec.pos_y   = i_in_data.pos_y;
        spawn_rec.vel_x   = i_in_data.vel_x;
        spawn_rec.vel_y   = i_in_data.vel_y;
        spawn_rec.accel_x = i_in_data.accel_x;
        spawn_rec.accel_y = r_grav;
        spawn_rec.life    = r_lmax;
        spawn_rec.color   = {i_in_data.red, i_in_data.green, i_in_data.blue};
    end

    assign live      = (r_new.life != '0);
    assign ram_we    = i_cmd.spawn || (i_cmd.wr && (r_rec.life != '0));
    assign ram_waddr = i_cmd.spawn ? r_wslot : r_idx;
    assign ram_wdata = i_cmd.spawn ? spawn_rec : r_new;

    ppk_ram #(
        .WIDTH($bits(t_slot)),
        .DEPTH(POOL_SLOTS)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd),
        .i_raddr(r_idx),
        .o_rdata(ram_q)
    );

    assign rec_q = r_rd_valid ? t_slot'(ram_q) : t_slot'('0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_valid <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.spawn) begin
                r_valid[r_wslot] <= 1'b1;
                r_wslot <= (r_wslot == LAST_IDX) ? '0 : r_wslot + 1'b1;
            end
            if (i_cmd.tick) begin
                r_idx <= '0;
            end else if (i_cmd.next) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
        end
    end

    assign dt_s   = $signed({1'b0, r_dt});
    assign dtsq_s = $signed({1'b0, r_dtsq});
    assign k_s    = $signed({1'b0, r_air});

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_dt <= i_in_data.time_step;
        end
        if (i_cmd.prep) begin
            r_dtsq <= r_dt * r_dt;
        end
        if (i_cmd.rd) begin
            r_rd_valid <= r_valid[r_idx];
        end
        if (i_cmd.mul) begin
            r_rec     <= rec_q;
            r_p_vxdt  <= $signed(rec_q.vel_x) * dt_s;
            r_p_vydt  <= $signed(rec_q.vel_y) * dt_s;
            r_p_axdt  <= $signed(rec_q.accel_x) * dt_s;
            r_p_aydt  <= $signed(rec_q.accel_y) * dt_s;
            r_p_axdt2 <= $signed(rec_q.accel_x) * dtsq_s;
            r_p_aydt2 <= $signed(rec_q.accel_y) * dtsq_s;
            r_p_vxk   <= $signed(rec_q.vel_x) * k_s;
        end
        if (i_cmd.upd) begin
            r_new <= n_new;
        end
    end

    always_comb begin
        s_x  = 36'($signed(r_rec.pos_x)) + 36'(ppk_rnd(66'(r_p_vxdt), 6'd16))
             + 36'(ppk_rnd(66'(r_p_axdt2), 6'd33));
        s_y  = 36'($signed(r_rec.pos_y)) + 36'(ppk_rnd(66'(r_p_vydt), 6'd16))
             + 36'(ppk_rnd(66'(r_p_aydt2), 6'd33));
        s_vx = 36'(ppk_rnd(66'(r_p_vxk), 6'd16)) + 36'(ppk_rnd(66'(r_p_axdt), 6'd16));
        s_vy = 36'($signed(r_rec.vel_y)) + 36'(ppk_rnd(66'(r_p_aydt), 6'd16));
        n_new = r_rec;
        if (r_rec.life != '0) begin
            n_new.pos_x   = ppk_sat(s_x);
            n_new.pos_y   = ppk_sat(s_y);
            n_new.vel_x   = ppk_sat(s_vx);
            n_new.vel_y   = ppk_sat(s_vy);
            n_new.accel_x = '0;
            n_new.life    = (r_rec.life > {16'b0, r_dt}) ? r_rec.life - {16'b0, r_dt} : '0;
        end
    end

    assign n_num = ({9'b0, r_new.life} << 8) - {9'b0, r_new.life} + {10'b0, r_lmax[31:1]};
    assign dsr   = {9'b0, r_lmax} << r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_rem <= n_num;
            r_q   <= '0;
            r_cnt <= 4'd8;
        end else if (i_cmd.step) begin
            if (r_rem >= dsr) begin
                r_rem      <= r_rem - dsr;
                r_q[r_cnt] <= 1'b1;
            end
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.fin) begin
            o_out_data.slot_index <= 6'(r_idx);
            o_out_data.visible    <= live;
            o_out_data.out_x      <= r_new.pos_x;
            o_out_data.out_y      <= r_new.pos_y;
            o_out_data.alpha      <= !live ? 8'd0 : (r_q[8] ? 8'd255 : r_q[7:0]);
            o_out_data.out_red    <= r_new.color[23:16];
            o_out_data.out_green  <= r_new.color[15:8];
            o_out_data.out_blue   <= r_new.color[7:0];
            o_out_data.last       <= (r_idx == LAST_IDX);
        end
    end

    assign o_sts.div_done = (r_cnt == 4'd0);
    assign o_sts.idx_last = (r_idx == LAST_IDX);
endmodule
`default_nettype wire

/* hw/rtl/particle_pool_kinematic_update_core.sv */
// Top level of the particle pool kinematic update core.
// A spawn transaction writes the next ring slot. A tick transaction runs a setup step that
// squares the time step and then, for each slot in turn: slot read, multiply, update,
// write-back, then a 9-step bit-per-cycle divider for alpha, result load and presentation,
// where it waits until the receiver takes the result. No input is taken during a tick.
`default_nettype none
module particle_pool_kinematic_update_core #(
    parameter int POOL_SLOTS = ppk_pkg::PPK_POOL_SLOTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ppk_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ppk_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import ppk_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    ppk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppk_dpath #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in_data  (i_in_data),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );
endmodule
`default_nettype wire

/* tb/particle_pool_kinematic_update_core_tb.sv */
// Self-checking testbench for the particle pool kinematic update core.
`timescale 1ns / 1ps
`default_nettype none
module particle_pool_kinematic_update_core_tb;
    import ppk_pkg::*;

    localparam int SLOTS = PPK_POOL_SLOTS;
    localparam int WATCHDOG_LIMIT = 20000;

    class pool_scoreboard;
        logic [16:0] air;
        logic signed [31:0] grav;
        logic [31:0] lmax;
        logic signed [31:0] px[SLOTS], py[SLOTS], vx[SLOTS], vy[SLOTS];
        logic signed [31:0] ax[SLOTS], ay[SLOTS];
        logic [31:0] life[SLOTS];
        logic [23:0] color[SLOTS];
        logic [5:0] wslot;
        t_out_item pending_reports[$];
        int errors;

        function void clear();
            air = AIR_RESET;
            grav = 0;
            lmax = LIFE_RESET;
            wslot = 0;
            errors = 0;
            for (int i = 0; i < SLOTS; i++) begin
                px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0;
                ax[i] = 0; ay[i] = 0; life[i] = 0; color[i] = 0;
            end
        endfunction

        function void write_reg(logic [7:0] idx, logic [31:0] val);
            if (idx == CFG_AIR_RESISTANCE) air = val[16:0];
            else if (idx == CFG_GRAVITY_ACCEL) grav = val;
            else if (idx == CFG_LIFE_MAX) lmax = val;
        endfunction

        function longint rnd_shr(longint x, int s);
            return (x + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFFFFFF;
            if (v < -64'sd2147483648) return 32'h80000000;
            return v[31:0];
        endfunction

        function logic [7:0] opacity(logic [31:0] l);
            longint unsigned a;
            if (l == 0) return 0;
            if (lmax == 0) return 8'd255;
            a = (longint'(l) * 255 + longint'(lmax / 2)) / longint'(lmax);
            return (a > 255) ? 8'd255 : a[7:0];
        endfunction

        function void note_input(t_in_item it);
            longint dt, dtsq, x, y, vxl, vyl, axl, ayl;
            t_out_item r;
            if (it.opcode == 1'b0) begin
                px[wslot] = it.pos_x; py[wslot] = it.pos_y;
                vx[wslot] = it.vel_x; vy[wslot] = it.vel_y;
                ax[wslot] = it.accel_x; ay[wslot] = grav;
                life[wslot] = lmax;
                color[wslot] = {it.red, it.green, it.blue};
                wslot = (wslot + 1) % SLOTS;
                return;
            end
            dt = it.time_step;
            dtsq = dt * dt;
            for (int i = 0; i < SLOTS; i++) begin
                if (life[i] != 0) begin
                    x = px[i]; y = py[i]; vxl = vx[i]; vyl = vy[i]; axl = ax[i]; ayl = ay[i];
                    px[i] = clamp32(x + rnd_shr(vxl * dt, 16) + rnd_shr(axl * dtsq, 33));
                    py[i] = clamp32(y + rnd_shr(vyl * dt, 16) + rnd_shr(ayl * dtsq, 33));
                    vx[i] = clamp32(rnd_shr(vxl * longint'(air), 16) + rnd_shr(axl * dt, 16));
                    vy[i] = clamp32(vyl + rnd_shr(ayl * dt, 16));
                    ax[i] = 0;
                    life[i] = (longint'(life[i]) > dt) ? life[i] - 32'(dt) : 32'd0;
                end
                r.slot_index = i;
                r.visible = life[i] != 0;
                r.out_x = px[i];
                r.out_y = py[i];
                r.alpha = opacity(life[i]);
                {r.out_red, r.out_green, r.out_blue} = color[i];
                r.last = (i == SLOTS - 1);
                pending_reports.push_back(r);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending_reports.size() == 0) begin
                report("unexpected report", 0, got);
                return;
            end
            e = pending_reports.pop_front();
            if (got.slot_index !== e.slot_index) report("slot_index", e.slot_index, got.slot_index);
            if (got.visible !== e.visible) report("visible", e.visible, got.visible);
            if (got.out_x !== e.out_x) report("out_x", e.out_x, got.out_x);
            if (got.out_y !== e.out_y) report("out_y", e.out_y, got.out_y);
            if (got.alpha !== e.alpha) report("alpha", e.alpha, got.alpha);
            if (got.out_red !== e.out_red) report("out_red", e.out_red, got.out_red);
            if (got.out_green !== e.out_green) report("out_green", e.out_green, got.out_green);
            if (got.out_blue !== e.out_blue) report("out_blue", e.out_blue, got.out_blue);
            if (got.last !== e.last) report("last", e.last, got.last);
        endfunction

        function void report(string what, logic [127:0] exp_v, logic [127:0] got_v);
            errors++;
            if (errors <= 40)
                $display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out_item o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [7:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    pool_scoreboard pool;
    int idle_cycles;
    bit quiet_phase;
    bit hold_off_req;
    bit hold_off_done;

    particle_pool_kinematic_update_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Monitor, checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) pool.note_input(i_in_data);
            if (o_out_valid && i_out_ready) pool.check_result(o_out_data);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("particle_pool_kinematic_update_core_tb NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        i_out_ready = 1'b0;
        hold_off_done = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_off_done = 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 30);
                i_out_ready <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(t_in_item it);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pool.pending_reports.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pool.pending_reports.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        pool.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item rand_spawn();
        t_in_item it;
        it.opcode = 1'b0;
        it.pos_x = $urandom; it.pos_y = $urandom;
        it.vel_x = $urandom; it.vel_y = $urandom; it.accel_x = $urandom;
        if ($urandom_range(0, 2) != 0) begin
            it.pos_x = $signed(it.pos_x) >>> 8; it.pos_y = $signed(it.pos_y) >>> 8;
            it.vel_x = $signed(it.vel_x) >>> 10; it.vel_y = $signed(it.vel_y) >>> 10;
            it.accel_x = $signed(it.accel_x) >>> 10;
        end
        it.red = $urandom; it.green = $urandom; it.blue = $urandom;
        it.time_step = $urandom;
        return it;
    endfunction

    function automatic t_in_item rand_tick();
        t_in_item it;
        it = rand_spawn();
        it.opcode = 1'b1;
        return it;
    endfunction

    function automatic t_in_item edge_spawn(logic [31:0] v, logic [7:0] c);
        t_in_item it;
        it = '0;
        it.pos_x = v; it.pos_y = v; it.vel_x = v; it.vel_y = v; it.accel_x = v;
        it.red = c; it.green = c; it.blue = c;
        it.time_step = 16'hFFFF;
        return it;
    endfunction

    function automatic t_in_item tick_of(logic [15:0] dt);
        t_in_item it;
        it = '0;
        it.opcode = 1'b1;
        it.time_step = dt;
        return it;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0) send_item(rand_tick());
            else send_item(rand_spawn());
        end
        go_idle();
    endtask

    initial begin
        pool = new();
        pool.clear();
        idle_cycles = 0;
        quiet_phase = 1'b0;
        hold_off_req = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_AIR_RESISTANCE;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pool, extremes, saturation, zero dt
        send_item(tick_of(16'd100));
        send_item(edge_spawn(32'h7FFFFFFF, 8'hFF));
        send_item(edge_spawn(32'h80000000, 8'h00));
        send_item(edge_spawn(32'h00000000, 8'hA5));
        send_item(edge_spawn(32'hFFFFFFFF, 8'h5A));
        send_item(tick_of(16'h0000));
        send_item(tick_of(16'hFFFF));
        send_item(tick_of(16'h0001));
        go_idle();

        // Amplifying air, large gravity, zero life_max
        write_reg(CFG_AIR_RESISTANCE, 32'h1FFFF);
        write_reg(CFG_GRAVITY_ACCEL, 32'h80000000);
        write_reg(CFG_LIFE_MAX, 32'd0);
        send_item(edge_spawn(32'h00010000, 8'h11));
        send_item(tick_of(16'h8000));
        write_reg(CFG_LIFE_MAX, 32'hFFFFFFFF);
        send_item(edge_spawn(32'hFFFF0000, 8'h22));
        send_item(tick_of(16'h8000));
        go_idle();

        // Life above a lowered life_max, then zero life_max on live slots
        write_reg(CFG_LIFE_MAX, 32'd1000);
        send_item(tick_of(16'd3));
        write_reg(CFG_LIFE_MAX, 32'd0);
        send_item(tick_of(16'd3));
        go_idle();

        write_reg(CFG_AIR_RESISTANCE, 32'd0);
        write_reg(CFG_GRAVITY_ACCEL, 32'h7FFFFFFF);
        write_reg(CFG_LIFE_MAX, 32'd1);
        random_phase(40);

        // Long receiver hold-off while input keeps coming
        write_reg(CFG_AIR_RESISTANCE, 32'd60000);
        write_reg(CFG_GRAVITY_ACCEL, 32'hFFF60000);
        write_reg(CFG_LIFE_MAX, 32'h00040000);
        hold_off_req = 1'b1;
        for (int i = 0; i < 20; i++) send_item(i % 4 == 3 ? rand_tick() : rand_spawn());
        go_idle();

        write_reg(CFG_AIR_RESISTANCE, 32'd65536);
        write_reg(CFG_GRAVITY_ACCEL, 32'h00098000);
        write_reg(CFG_LIFE_MAX, 32'h00020000);
        random_phase(80);

        write_reg(CFG_AIR_RESISTANCE, $urandom_range(0, 65536));
        write_reg(CFG_GRAVITY_ACCEL, $urandom);
        write_reg(CFG_LIFE_MAX, $urandom_range(1, 32'h00080000));
        random_phase(60);

        quiet_phase = 1'b1;
        random_phase(40);

        if (pool.errors == 0) begin
            $display("particle_pool_kinematic_update_core_tb OK");
        end else begin
            $display("particle_pool_kinematic_update_core_tb NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
